@@ hw/rtl/frc_pkg.sv @@
`default_nettype none
package frc_pkg;

   // table sizes
   localparam int RULE_ENTRIES = 64;
   localparam int INST_ENTRIES = 64;
   localparam int RULE_AW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
   localparam int INST_AW = (INST_ENTRIES > 1) ? $clog2(INST_ENTRIES) : 1;

   // configuration register indexes
   localparam logic CSR_DEFAULT_ACTION  = 1'b0;
   localparam logic CSR_DEFAULT_RULE_ID = 1'b1;

   typedef enum logic [2:0] {
      MODE_LOOKUP    = 3'd0,
      MODE_WR_RULE   = 3'd1,
      MODE_CLR_RULE  = 3'd2,
      MODE_WR_INST   = 3'd3,
      MODE_CLR_INST  = 3'd4,
      MODE_NOP       = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      V_ALLOW   = 2'd0,
      V_DROP    = 2'd1,
      V_CONNECT = 2'd2,
      V_EST     = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INST,
      S_RULE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [15:0] port;
      logic [31:0] ip;
   } endpoint_type;

   typedef struct packed {
      logic         wild;
      logic [5:0]   prefix;
      endpoint_type ep;
   } side_type;

   typedef struct packed {
      verdict_type action;
      logic [15:0] ident;
   } rule_meta_type;

   // one classified request, as held in the queue
   typedef struct packed {
      mode_type      mode;
      logic          slot_ok;
      logic [5:0]    slot;
      side_type      src;
      side_type      dst;
      rule_meta_type meta;
   } cmd_type;

   // action code 3 reads as drop
   function automatic verdict_type fix_action(input logic [1:0] a);
      fix_action = (a == 2'd3) ? V_DROP : verdict_type'(a);
   endfunction

   // prefix lengths are saturated to 32 before storing
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      prefix_mask = ~(32'hFFFF_FFFF >> len);
   endfunction

   function automatic logic side_match(input side_type s, input endpoint_type e);
      side_match = (s.wild || (s.ep.port == e.port)) &&
                   (((s.ep.ip ^ e.ip) & prefix_mask(s.prefix)) == 32'd0);
   endfunction

   // true when rule a is strictly more specific than rule b
   function automatic logic beats(input side_type as, input side_type ad,
                                  input side_type bs, input side_type bd);
      if (as.prefix != bs.prefix)
         beats = as.prefix > bs.prefix;
      else if (ad.prefix != bd.prefix)
         beats = ad.prefix > bd.prefix;
      else if (as.wild != bs.wild)
         beats = !as.wild;
      else
         beats = !ad.wild && bd.wild;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/frc_chan_if.sv @@
`default_nettype none
interface frc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [5:0]  slot;
   logic [31:0] src_ip;
   logic [15:0] src_l4_port;
   logic [31:0] dst_ip;
   logic [15:0] dst_l4_port;
   logic [5:0]  src_prefix;
   logic [5:0]  dst_prefix;
   logic        src_l4_wild;
   logic        dst_l4_wild;
   logic [1:0]  rule_action;
   logic [15:0] rule_ident;

   modport source (output valid, mode, slot, src_ip, src_l4_port, dst_ip, dst_l4_port,
                   src_prefix, dst_prefix, src_l4_wild, dst_l4_wild,
                   rule_action, rule_ident, input ready);
   modport sink (input valid, mode, slot, src_ip, src_l4_port, dst_ip, dst_l4_port,
                 src_prefix, dst_prefix, src_l4_wild, dst_l4_wild,
                 rule_action, rule_ident, output ready);
endinterface

interface frc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [15:0] matched_rule_id;
   logic        instance_hit;
   logic [5:0]  instance_index;

   modport source (output valid, verdict, matched_rule_id, instance_hit,
                   instance_index, input ready);
   modport sink (input valid, verdict, matched_rule_id, instance_hit,
                 instance_index, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/frc_front.sv @@
`default_nettype none
module frc_front
   import frc_pkg::*;
(
   frc_req_if.sink  req,
   input  logic     q_full,
   output logic     q_push,
   output cmd_type  q_cmd
);

   logic [5:0] spre;
   logic [5:0] dpre;

   // saturate prefixes to the address width
   assign spre = (req.src_prefix > 6'd32) ? 6'd32 : req.src_prefix;
   assign dpre = (req.dst_prefix > 6'd32) ? 6'd32 : req.dst_prefix;

   // accept while the queue has room
   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   // classify the request
   always_comb begin
      q_cmd = '0;
      unique case (req.mode) inside
         MODE_LOOKUP: begin
            q_cmd.mode    = MODE_LOOKUP;
            q_cmd.slot_ok = 1'b1;
         end
         MODE_WR_RULE, MODE_CLR_RULE: begin
            q_cmd.mode    = mode_type'(req.mode);
            q_cmd.slot_ok = int'(req.slot) < RULE_ENTRIES;
         end
         MODE_WR_INST, MODE_CLR_INST: begin
            q_cmd.mode    = mode_type'(req.mode);
            q_cmd.slot_ok = int'(req.slot) < INST_ENTRIES;
         end
         default: begin
            q_cmd.mode    = MODE_NOP;
            q_cmd.slot_ok = 1'b0;
         end
      endcase
      q_cmd.slot        = req.slot;
      q_cmd.src.wild    = req.src_l4_wild;
      q_cmd.src.prefix  = spre;
      q_cmd.src.ep.port = req.src_l4_port;
      q_cmd.src.ep.ip   = req.src_ip;
      q_cmd.dst.wild    = req.dst_l4_wild;
      q_cmd.dst.prefix  = dpre;
      q_cmd.dst.ep.port = req.dst_l4_port;
      q_cmd.dst.ep.ip   = req.dst_ip;
      q_cmd.meta.action = fix_action(req.rule_action);
      q_cmd.meta.ident  = req.rule_ident;
   end

endmodule
`default_nettype wire

@@ hw/rtl/frc_cmd_fifo.sv @@
`default_nettype none
module frc_cmd_fifo
   import frc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full       = cnt_ff == 2'd2;
   assign head_valid = cnt_ff != 2'd0;
   assign head_cmd   = slot_ff[rptr_ff];

   // advance pointers and count
   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wptr_ff] <= push_cmd;
   end

endmodule
`default_nettype wire

@@ hw/rtl/frc_back.sv @@
`default_nettype none
module frc_back
   import frc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   frc_rsp_if.source   rsp
);

   localparam logic [INST_AW-1:0] INST_LAST = INST_AW'(INST_ENTRIES - 1);
   localparam logic [RULE_AW-1:0] RULE_LAST = RULE_AW'(RULE_ENTRIES - 1);

   // tables
   side_type      rule_src_mem [RULE_ENTRIES];
   side_type      rule_dst_mem [RULE_ENTRIES];
   rule_meta_type rule_meta_mem [RULE_ENTRIES];
   endpoint_type  inst_src_mem [INST_ENTRIES];
   endpoint_type  inst_dst_mem [INST_ENTRIES];
   logic [15:0]   inst_id_mem [INST_ENTRIES];

   logic [RULE_ENTRIES-1:0] rvalid_ff, rvalid_in;
   logic [INST_ENTRIES-1:0] ivalid_ff, ivalid_in;

   side_type      rd_rsrc_ff, rd_rdst_ff;
   rule_meta_type rd_rmeta_ff;
   endpoint_type  rd_isrc_ff, rd_idst_ff;
   logic [15:0]   rd_iid_ff;

   logic rule_we, inst_we;
   logic [RULE_AW-1:0] rule_waddr;
   logic [INST_AW-1:0] inst_waddr;

   state_type state_ff, state_in;
   verdict_type def_action_ff, def_action_in;
   logic [15:0] def_id_ff, def_id_in;

   endpoint_type pkt_src_ff, pkt_src_in, pkt_dst_ff, pkt_dst_in;

   logic [INST_AW-1:0] icnt_ff, icnt_in, ichk_idx_ff, ichk_idx_in;
   logic [RULE_AW-1:0] rcnt_ff, rcnt_in, rchk_idx_ff, rchk_idx_in;
   logic iss_ff, iss_in, chk_ff, chk_in;

   logic hit_ff, hit_in;
   logic [5:0] hit_idx_ff, hit_idx_in;
   logic [15:0] hit_id_ff, hit_id_in;
   logic found_ff, found_in;
   side_type best_src_ff, best_src_in, best_dst_ff, best_dst_in;
   rule_meta_type best_meta_ff, best_meta_in;

   logic rsp_vld_ff, rsp_vld_in;
   verdict_type rsp_verdict_ff, rsp_verdict_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic [5:0] rsp_idx_ff, rsp_idx_in;

   logic out_free, inst_match, rule_match;

   assign rsp.valid           = rsp_vld_ff;
   assign rsp.verdict         = rsp_verdict_ff;
   assign rsp.matched_rule_id = rsp_id_ff;
   assign rsp.instance_hit    = rsp_hit_ff;
   assign rsp.instance_index  = rsp_idx_ff;

   assign out_free   = !rsp_vld_ff || rsp.ready;
   assign rule_waddr = RULE_AW'(q_cmd.slot);
   assign inst_waddr = INST_AW'(q_cmd.slot);

   // instance matches in either direction
   assign inst_match = ivalid_ff[ichk_idx_ff] &&
      ((rd_isrc_ff == pkt_src_ff && rd_idst_ff == pkt_dst_ff) ||
       (rd_isrc_ff == pkt_dst_ff && rd_idst_ff == pkt_src_ff));
   assign rule_match = rvalid_ff[rchk_idx_ff] &&
      side_match(rd_rsrc_ff, pkt_src_ff) && side_match(rd_rdst_ff, pkt_dst_ff);

   // sequencer: take a command; lookups scan instances, rules if none hit, report
   always_comb begin
      state_in       = state_ff;
      q_pop          = 1'b0;
      rule_we        = 1'b0;
      inst_we        = 1'b0;
      rvalid_in      = rvalid_ff;
      ivalid_in      = ivalid_ff;
      def_action_in  = def_action_ff;
      def_id_in      = def_id_ff;
      pkt_src_in     = pkt_src_ff;
      pkt_dst_in     = pkt_dst_ff;
      icnt_in        = icnt_ff;
      rcnt_in        = rcnt_ff;
      ichk_idx_in    = ichk_idx_ff;
      rchk_idx_in    = rchk_idx_ff;
      iss_in         = iss_ff;
      chk_in         = 1'b0;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_id_in      = hit_id_ff;
      found_in       = found_ff;
      best_src_in    = best_src_ff;
      best_dst_in    = best_dst_ff;
      best_meta_in   = best_meta_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp.ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_idx_in     = rsp_idx_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_DEFAULT_ACTION:  def_action_in = fix_action(csr_wdata[1:0]);
            default:             def_id_in     = csr_wdata;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && q_cmd.mode == MODE_LOOKUP) begin
               q_pop      = 1'b1;
               pkt_src_in = q_cmd.src.ep;
               pkt_dst_in = q_cmd.dst.ep;
               icnt_in    = '0;
               iss_in     = 1'b1;
               hit_in     = 1'b0;
               found_in   = 1'b0;
               state_in   = S_INST;
            end else if (q_valid && out_free) begin
               // table updates and no-ops answer at once with an all-zero result
               q_pop          = 1'b1;
               rsp_vld_in     = 1'b1;
               rsp_verdict_in = V_ALLOW;
               rsp_id_in      = '0;
               rsp_hit_in     = 1'b0;
               rsp_idx_in     = '0;
               if (q_cmd.slot_ok) begin
                  case (q_cmd.mode)
                     MODE_WR_RULE: begin
                        rule_we               = 1'b1;
                        rvalid_in[rule_waddr] = 1'b1;
                     end
                     MODE_CLR_RULE: rvalid_in[rule_waddr] = 1'b0;
                     MODE_WR_INST: begin
                        inst_we               = 1'b1;
                        ivalid_in[inst_waddr] = 1'b1;
                     end
                     MODE_CLR_INST: ivalid_in[inst_waddr] = 1'b0;
                     default: ;
                  endcase
               end
            end
         end
         S_INST: begin
            if (iss_ff) begin
               chk_in      = 1'b1;
               ichk_idx_in = icnt_ff;
               if (icnt_ff == INST_LAST)
                  iss_in = 1'b0;
               else
                  icnt_in = icnt_ff + 1'b1;
            end
            if (chk_ff) begin
               if (inst_match) begin
                  hit_in     = 1'b1;
                  hit_idx_in = 6'(ichk_idx_ff);
                  hit_id_in  = rd_iid_ff;
                  chk_in     = 1'b0;
                  state_in   = S_FINISH;
               end else if (ichk_idx_ff == INST_LAST) begin
                  rcnt_in  = '0;
                  iss_in   = 1'b1;
                  chk_in   = 1'b0;
                  state_in = S_RULE;
               end
            end
         end
         S_RULE: begin
            if (iss_ff) begin
               chk_in      = 1'b1;
               rchk_idx_in = rcnt_ff;
               if (rcnt_ff == RULE_LAST)
                  iss_in = 1'b0;
               else
                  rcnt_in = rcnt_ff + 1'b1;
            end
            if (chk_ff) begin
               // keep the most specific; ties keep the earlier slot
               if (rule_match && (!found_ff ||
                   beats(rd_rsrc_ff, rd_rdst_ff, best_src_ff, best_dst_ff))) begin
                  found_in     = 1'b1;
                  best_src_in  = rd_rsrc_ff;
                  best_dst_in  = rd_rdst_ff;
                  best_meta_in = rd_rmeta_ff;
               end
               if (rchk_idx_ff == RULE_LAST) begin
                  chk_in   = 1'b0;
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_hit_in = hit_ff;
               if (hit_ff) begin
                  rsp_verdict_in = V_EST;
                  rsp_id_in      = hit_id_ff;
                  rsp_idx_in     = hit_idx_ff;
               end else if (found_ff) begin
                  rsp_verdict_in = best_meta_ff.action;
                  rsp_id_in      = best_meta_ff.ident;
                  rsp_idx_in     = '0;
               end else begin
                  rsp_verdict_in = def_action_ff;
                  rsp_id_in      = def_id_ff;
                  rsp_idx_in     = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rvalid_ff     <= '0;
         ivalid_ff     <= '0;
         def_action_ff <= V_DROP;
         def_id_ff     <= '0;
         iss_ff        <= 1'b0;
         chk_ff        <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rvalid_ff     <= rvalid_in;
         ivalid_ff     <= ivalid_in;
         def_action_ff <= def_action_in;
         def_id_ff     <= def_id_in;
         iss_ff        <= iss_in;
         chk_ff        <= chk_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   // scan datapath and result payload
   always_ff @(posedge clock) begin
      pkt_src_ff     <= pkt_src_in;
      pkt_dst_ff     <= pkt_dst_in;
      icnt_ff        <= icnt_in;
      rcnt_ff        <= rcnt_in;
      ichk_idx_ff    <= ichk_idx_in;
      rchk_idx_ff    <= rchk_idx_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      hit_id_ff      <= hit_id_in;
      found_ff       <= found_in;
      best_src_ff    <= best_src_in;
      best_dst_ff    <= best_dst_in;
      best_meta_ff   <= best_meta_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_idx_ff     <= rsp_idx_in;
   end

   // rule table: one write, one registered read
   always_ff @(posedge clock) begin
      if (rule_we) begin
         rule_src_mem[rule_waddr]  <= q_cmd.src;
         rule_dst_mem[rule_waddr]  <= q_cmd.dst;
         rule_meta_mem[rule_waddr] <= q_cmd.meta;
      end
      rd_rsrc_ff  <= rule_src_mem[rcnt_ff];
      rd_rdst_ff  <= rule_dst_mem[rcnt_ff];
      rd_rmeta_ff <= rule_meta_mem[rcnt_ff];
   end

   // instance table: one write, one registered read
   always_ff @(posedge clock) begin
      if (inst_we) begin
         inst_src_mem[inst_waddr] <= q_cmd.src.ep;
         inst_dst_mem[inst_waddr] <= q_cmd.dst.ep;
         inst_id_mem[inst_waddr]  <= q_cmd.meta.ident;
      end
      rd_isrc_ff <= inst_src_mem[icnt_ff];
      rd_idst_ff <= inst_dst_mem[icnt_ff];
      rd_iid_ff  <= inst_id_mem[icnt_ff];
   end

   a_hit_is_established: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_hit_ff |-> rsp_verdict_ff == V_EST)
      else $error("instance hit reported without established verdict");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE)
      else $error("command taken while a lookup is in progress");

   a_no_hit_in_rule_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RULE |-> !hit_ff)
      else $error("rule scan running after an instance hit");

endmodule
`default_nettype wire

@@ hw/rtl/firewall_rule_classifier.sv @@
// One request is looked up at a time, set by the single read port of each
// table, which is scanned one slot per cycle while a lookup runs.
// Table writes and clears pass the queue and answer from the idle back with a
// registered result. A two-entry queue takes requests while a lookup runs.
// Synchronous active-high reset clears all valid bits, default action drop,
// rule id 0; no clearing pass.
`default_nettype none
module firewall_rule_classifier
   import frc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   frc_req_if.sink     req_chan,
   frc_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic    q_full, q_push, q_pop, q_valid;
   cmd_type push_cmd, head_cmd;

   frc_front u_front (
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (push_cmd)
   );

   frc_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   frc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (head_cmd),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_chan)
   );

endmodule
`default_nettype wire
